/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, record layout and sequencer state type.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int HeapOrder   = 16;
  localparam int MinOrder    = 3;
  localparam int HeaderBytes = 24;
  localparam int MaxOrder    = 32;
  localparam int NumLists    = MaxOrder + 1;
  localparam int IdxW        = HeapOrder - MinOrder;
  localparam int NumRecs     = 1 << IdxW;
  localparam int LvlW        = 6;
  localparam int CntW        = 17;
  localparam int AddrW       = 48;
  localparam int ReqW        = 40;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoSpace = 3'd1;
  localparam logic [2:0] StTooBig  = 3'd2;
  localparam logic [2:0] StBlocked = 3'd3;
  localparam logic [2:0] StBadFree = 3'd4;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // One block record: level, allocated flag, list links.
  typedef struct packed {
    logic [LvlW-1:0] level;
    logic            alloc;
    logic            has_next;
    logic            has_prev;
    logic [IdxW-1:0] next;
    logic [IdxW-1:0] prev;
  } rec_t;

  // Record memory request from the sequencer.
  typedef struct packed {
    logic            rd;
    logic            wr;
    logic [IdxW-1:0] addr;
    rec_t            wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_SEARCH, S_UL_RD, S_UL_WAIT, S_UL_PREV_RD,
    S_UL_PREV_WAIT, S_UL_PREV_WR, S_UL_NEXT_RD, S_UL_NEXT_WAIT, S_UL_NEXT_WR,
    S_UL_SELF_WR, S_PUSH_HD_RD, S_PUSH_HD_WAIT, S_PUSH_HD_WR, S_PUSH_WR, S_SPLIT,
    S_FIN_ALLOC, S_FREE_RD, S_FREE_WAIT, S_BUD_RD, S_BUD_WAIT, S_MERGE,
    S_DONE
  } state_t;

endpackage

/* rtl/core/bba_rec_mem.sv */
// ----------------------------------------------------------------------------
// Block record memory
// Single-port synchronous RAM holding one record per 8-byte granule.
// ----------------------------------------------------------------------------
module bba_rec_mem
  import bba_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rdata
);

  rec_t mem [NumRecs];

  // Write and registered read on one port.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* rtl/core/bba_seq.sv */
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Walks orders for search, split and merge, with list edits in record memory.
// ----------------------------------------------------------------------------
module bba_seq
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [AddrW-1:0] heap_base,
  input  logic             start,
  input  logic             cmd,
  input  logic [ReqW-1:0]  req_bytes,
  input  logic [AddrW-1:0] pay_addr,
  output logic             busy,
  output logic             done,
  output logic [2:0]       res_status,
  output logic [AddrW-1:0] res_addr,
  output logic [CntW-1:0]  res_used,
  output mem_req_t         mreq,
  input  rec_t             mrdata
);

  state_t state, state_next;

  // Free-list heads, one per order.
  logic [NumLists-1:0] hvalid;
  logic [IdxW-1:0]     hidx [NumLists];

  logic [CntW-1:0]  used;
  logic             err;
  logic [2:0]       status;
  logic [AddrW-1:0] gaddr;
  logic             op;
  logic [ReqW:0]    size;
  logic [AddrW-1:0] fr_addr;   // payload address of the command in work
  logic [LvlW-1:0]  want;      // requested order
  logic [LvlW-1:0]  lvl;       // current order
  logic [IdxW-1:0]  idx;       // block being worked
  logic [IdxW-1:0]  bidx;      // buddy
  logic [IdxW-1:0]  uidx;      // record being unlinked
  rec_t             urec;
  logic [IdxW-1:0]  pidx;      // record being pushed
  logic [LvlW-1:0]  plvl;
  logic [1:0]       step;      // merge sub-step
  logic             in_merge;
  rec_t             tmp;

  logic [AddrW-1:0] off;
  logic [LvlW-1:0]  size_lvl;
  logic             bud_ok;
  logic [IdxW:0]    lvl_bit;

  // Order of the rounded request size: the bit length of size-1.
  always_comb begin
    size_lvl = '0;
    for (int b = 0; b <= ReqW; b++) begin
      if (((size - 1'b1) >> b) != '0) size_lvl = LvlW'(b + 1);
    end
  end

  assign off = fr_addr - AddrW'(HeaderBytes) - heap_base;
  assign lvl_bit = (lvl >= LvlW'(MinOrder)) ? ((IdxW+1)'(1) << (lvl - LvlW'(MinOrder)))
                                            : '0;
  assign bud_ok = !mrdata.alloc && mrdata.level == lvl;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:         state_next = S_IDLE;
      S_IDLE:         if (start) state_next = S_DECODE;
      S_DECODE: begin
        if (err) state_next = S_DONE;
        else if (op == CmdAlloc) begin
          if (size_lvl > LvlW'(MaxOrder)) state_next = S_DONE;
          else state_next = S_SEARCH;
        end else begin
          if (fr_addr == '0 || off >= AddrW'(1 << HeapOrder) || off[2:0] != 3'd0)
            state_next = S_DONE;
          else state_next = S_FREE_RD;
        end
      end
      S_SEARCH: begin
        if (lvl > LvlW'(MaxOrder)) state_next = S_DONE;
        else if (hvalid[lvl[5:0]]) state_next = S_UL_RD;
      end
      S_UL_RD:        state_next = S_UL_WAIT;
      S_UL_WAIT:      state_next = mrdata.has_prev ? S_UL_PREV_RD :
                                   (mrdata.has_next ? S_UL_NEXT_RD : S_UL_SELF_WR);
      S_UL_PREV_RD:   state_next = S_UL_PREV_WAIT;
      S_UL_PREV_WAIT: state_next = S_UL_PREV_WR;
      S_UL_PREV_WR:   state_next = urec.has_next ? S_UL_NEXT_RD : S_UL_SELF_WR;
      S_UL_NEXT_RD:   state_next = S_UL_NEXT_WAIT;
      S_UL_NEXT_WAIT: state_next = S_UL_NEXT_WR;
      S_UL_NEXT_WR:   state_next = S_UL_SELF_WR;
      S_UL_SELF_WR: begin
        if (!in_merge) state_next = S_SPLIT;
        else if (step == 2'd0) state_next = S_UL_RD;
        else state_next = S_PUSH_HD_RD;
      end
      S_SPLIT:        state_next = (lvl > want) ? S_PUSH_HD_RD : S_FIN_ALLOC;
      S_PUSH_HD_RD:   state_next = hvalid[plvl] ? S_PUSH_HD_WAIT : S_PUSH_WR;
      S_PUSH_HD_WAIT: state_next = S_PUSH_HD_WR;
      S_PUSH_HD_WR:   state_next = S_PUSH_WR;
      S_PUSH_WR:      state_next = in_merge ? S_MERGE : S_SPLIT;
      S_FIN_ALLOC:    state_next = S_DONE;
      S_FREE_RD:      state_next = S_FREE_WAIT;
      S_FREE_WAIT:    state_next = (!mrdata.alloc || mrdata.level > LvlW'(HeapOrder)) ?
                                   S_DONE : S_PUSH_HD_RD;
      S_MERGE:        state_next = (lvl < LvlW'(HeapOrder)) ? S_BUD_RD : S_DONE;
      S_BUD_RD:       state_next = S_BUD_WAIT;
      S_BUD_WAIT:     state_next = bud_ok ? S_UL_RD : S_DONE;
      S_DONE:         state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  // Memory request outputs.
  always_comb begin
    mreq = '0;
    tmp  = urec;
    unique case (state)
      S_INIT: begin
        // The root block starts free at the heap order.
        tmp = '0; tmp.level = LvlW'(HeapOrder);
        mreq.wr = 1'b1; mreq.addr = '0; mreq.wdata = tmp;
      end
      S_UL_RD: begin
        mreq.rd = 1'b1; mreq.addr = uidx;
      end
      S_UL_PREV_RD: begin
        mreq.rd = 1'b1; mreq.addr = urec.prev;
      end
      S_UL_PREV_WR: begin
        tmp = mrdata; tmp.has_next = urec.has_next; tmp.next = urec.next;
        mreq.wr = 1'b1; mreq.addr = urec.prev; mreq.wdata = tmp;
      end
      S_UL_NEXT_RD: begin
        mreq.rd = 1'b1; mreq.addr = urec.next;
      end
      S_UL_NEXT_WR: begin
        tmp = mrdata; tmp.has_prev = urec.has_prev; tmp.prev = urec.prev;
        mreq.wr = 1'b1; mreq.addr = urec.next; mreq.wdata = tmp;
      end
      S_UL_SELF_WR: begin
        tmp = urec; tmp.has_next = 1'b0; tmp.has_prev = 1'b0;
        mreq.wr = 1'b1; mreq.addr = uidx; mreq.wdata = tmp;
      end
      S_PUSH_HD_RD: begin
        mreq.rd = 1'b1; mreq.addr = hidx[plvl];
      end
      S_PUSH_HD_WR: begin
        tmp = mrdata; tmp.has_prev = 1'b1; tmp.prev = pidx;
        mreq.wr = 1'b1; mreq.addr = hidx[plvl]; mreq.wdata = tmp;
      end
      S_PUSH_WR: begin
        tmp = '0; tmp.level = LvlW'(plvl); tmp.has_next = hvalid[plvl];
        tmp.next = hidx[plvl];
        mreq.wr = 1'b1; mreq.addr = pidx; mreq.wdata = tmp;
      end
      S_FIN_ALLOC: begin
        tmp = '0; tmp.level = want; tmp.alloc = 1'b1;
        mreq.wr = 1'b1; mreq.addr = idx; mreq.wdata = tmp;
      end
      S_FREE_RD: begin
        mreq.rd = 1'b1; mreq.addr = off[HeapOrder-1:MinOrder];
      end
      S_BUD_RD: begin
        mreq.rd = 1'b1; mreq.addr = bidx;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      hvalid <= {{(NumLists-HeapOrder-1){1'b0}}, 1'b1, {HeapOrder{1'b0}}};
      for (int k = 0; k < NumLists; k++) hidx[k] <= '0;
      used   <= '0;
      err    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (start) begin
          op       <= cmd;
          size     <= ({1'b0, req_bytes} + (ReqW+1)'(HeaderBytes) < (ReqW+1)'(8)) ?
                      (ReqW+1)'(8) : {1'b0, req_bytes} + (ReqW+1)'(HeaderBytes);
          fr_addr  <= pay_addr;
          in_merge <= 1'b0;
          gaddr    <= '0;
        end
        S_DECODE: begin
          want <= size_lvl;
          lvl  <= size_lvl;
          if (err) status <= StBlocked;
          else if (op == CmdAlloc) begin
            if (size_lvl > LvlW'(MaxOrder)) begin
              status <= StTooBig; err <= 1'b1;
            end
          end else begin
            status <= StBadFree;
            idx    <= off[HeapOrder-1:MinOrder];
          end
        end
        S_SEARCH: begin
          if (lvl > LvlW'(MaxOrder)) status <= StNoSpace;
          else if (hvalid[lvl[5:0]]) begin
            idx  <= hidx[lvl[5:0]];
            uidx <= hidx[lvl[5:0]];
          end else lvl <= lvl + 1'b1;
        end
        S_UL_WAIT: begin
          urec <= mrdata;
          if (!mrdata.has_prev && mrdata.level < LvlW'(NumLists)) begin
            hvalid[mrdata.level[5:0]] <= mrdata.has_next;
            hidx[mrdata.level[5:0]]   <= mrdata.next;
          end
        end
        S_UL_SELF_WR: if (in_merge) begin
          if (step == 2'd0) begin
            step <= 2'd1; uidx <= idx;
          end else begin
            if (bidx < idx) idx <= bidx;
            pidx <= (bidx < idx) ? bidx : idx;
            plvl <= lvl[5:0] + 1'b1;
            lvl  <= lvl + 1'b1;
          end
        end
        S_SPLIT: if (lvl > want) begin
          lvl  <= lvl - 1'b1;
          plvl <= lvl[5:0] - 1'b1;
          pidx <= idx + IdxW'(lvl_bit >> 1);
        end
        S_PUSH_WR: begin
          hvalid[plvl] <= 1'b1;
          hidx[plvl]   <= pidx;
        end
        S_FIN_ALLOC: begin
          status <= StOk;
          used   <= used + (CntW'(1) << want);
          gaddr  <= heap_base + {{(AddrW-IdxW-MinOrder){1'b0}}, idx, {MinOrder{1'b0}}}
                    + AddrW'(HeaderBytes);
        end
        S_FREE_WAIT: if (!(!mrdata.alloc || mrdata.level > LvlW'(HeapOrder))) begin
          status   <= StOk;
          lvl      <= mrdata.level;
          plvl     <= mrdata.level[5:0];
          pidx     <= idx;
          in_merge <= 1'b1;
          used     <= used - (CntW'(1) << mrdata.level);
        end
        S_MERGE: begin
          bidx <= idx ^ IdxW'(lvl_bit);
          step <= 2'd0;
          uidx <= idx ^ IdxW'(lvl_bit);
        end
        default: ;
      endcase
    end
  end

  assign busy       = state != S_IDLE;
  assign done       = state == S_DONE;
  assign res_status = status;
  assign res_addr   = gaddr;
  assign res_used   = used;

endmodule

/* rtl/core/buddy_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator
// Stream command in, one status word out, APB register for the heap base.
// ----------------------------------------------------------------------------
// One command at a time. Every record access goes through a single-port RAM
// with a registered read. After acceptance a command passes through decode,
// a search step per order searched, list unlinks and list pushes (one push per
// split, and a buddy read, two unlinks and a push per merge level), and a final
// done state, from which the result word is loaded into the output register.
// The next command is taken once the sequencer is idle and the result word has
// been accepted. Right after reset the input is held off while the root record
// is written.
module buddy_block_allocator_top
  import bba_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // command, request_bytes, payload_address, zeros
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata   // status, granted_address, used_bytes, free_bytes, zeros
);

  logic [AddrW-1:0] heap_base;
  logic             start, busy, done;
  logic [2:0]       res_status;
  logic [AddrW-1:0] res_addr;
  logic [CntW-1:0]  res_used;
  mem_req_t         mreq;
  rec_t             mrdata;
  logic             ovalid;
  logic [87:0]      odata;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {16'd0, heap_base} : 64'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      heap_base <= pwdata[AddrW-1:0];
    end
  end

  assign s_axis_tready = !busy && !ovalid;
  assign start = s_axis_tvalid && s_axis_tready;

  bba_seq u_seq (
    .clk, .rst, .heap_base, .start,
    .cmd(s_axis_tdata[0]),
    .req_bytes(s_axis_tdata[40:1]),
    .pay_addr(s_axis_tdata[88:41]),
    .busy, .done, .res_status, .res_addr, .res_used,
    .mreq, .mrdata
  );

  bba_rec_mem u_mem (.clk, .req(mreq), .rdata(mrdata));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (done) begin
      ovalid <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) begin
      odata <= {3'd0, CntW'((CntW'(1) << HeapOrder) - res_used), res_used, res_addr,
                res_status};
    end
  end
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;

`ifndef NO_ASSERTIONS
  // A result appears only after a command was taken.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without command");
  // No command is taken while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (rst) ovalid |-> !start)
    else $error("command taken over pending result");
  // Used plus free equals the heap size.
  a_sum: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (m_axis_tdata[84:68] + m_axis_tdata[67:51]) == 17'h10000)
    else $error("byte counts inconsistent");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free commands with random gaps and stalls on both stream
// sides. A local predictor keeps its own block records and free lists and
// works out each status word, which the checker compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegHeapBase = 3'd0;
  localparam logic [47:0] AddrMask = 48'hFFFF_FFFF_FFFF;
  localparam int HeapBytes = 1 << HeapOrder;
  localparam int StallLimit = 5000;

  typedef struct {
    logic [2:0]  status;
    logic [47:0] granted;
    logic [16:0] used;
    logic [16:0] free_b;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;  // command, request_bytes, payload_address, zeros
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;       // status, granted_address, used_bytes, free_bytes, zeros

  buddy_block_allocator_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: one record per 8-byte granule plus LIFO list heads.
  logic [5:0]      rec_level [NumRecs];
  bit              rec_alloc [NumRecs];
  bit              rec_has_next [NumRecs];
  bit              rec_has_prev [NumRecs];
  logic [IdxW-1:0] rec_next [NumRecs];
  logic [IdxW-1:0] rec_prev [NumRecs];
  bit              rec_written [NumRecs];
  bit              head_valid [NumLists];
  logic [IdxW-1:0] head_idx [NumLists];
  int unsigned     used_total;
  bit              sticky_error;
  logic [47:0]     heap_base;

  reply_t      pending_replies[$];
  int          live_offsets[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_go;
  int          idle_cycles;

  function automatic void list_push(int idx, int lvl);
    rec_level[idx] = lvl[5:0];
    rec_alloc[idx] = 1'b0;
    rec_written[idx] = 1'b1;
    rec_has_prev[idx] = 1'b0;
    rec_has_next[idx] = head_valid[lvl];
    rec_next[idx] = head_idx[lvl];
    if (head_valid[lvl]) begin
      rec_has_prev[head_idx[lvl]] = 1'b1;
      rec_prev[head_idx[lvl]] = idx[IdxW-1:0];
    end
    head_valid[lvl] = 1'b1;
    head_idx[lvl] = idx[IdxW-1:0];
  endfunction

  function automatic void list_unlink(int idx);
    int lvl;
    lvl = rec_level[idx];
    if (rec_has_prev[idx]) begin
      rec_has_next[rec_prev[idx]] = rec_has_next[idx];
      rec_next[rec_prev[idx]] = rec_next[idx];
    end else if (lvl < NumLists) begin
      head_valid[lvl] = rec_has_next[idx];
      head_idx[lvl] = rec_next[idx];
    end
    if (rec_has_next[idx]) begin
      rec_has_prev[rec_next[idx]] = rec_has_prev[idx];
      rec_prev[rec_next[idx]] = rec_prev[idx];
    end
    rec_has_next[idx] = 1'b0;
    rec_has_prev[idx] = 1'b0;
  endfunction

  function automatic reply_t make_reply(logic [2:0] st, logic [47:0] addr);
    reply_t r;
    r.status = st;
    r.granted = addr;
    r.used = used_total[16:0];
    r.free_b = 17'(HeapBytes - used_total);
    return r;
  endfunction

  function automatic void reset_allocator();
    for (int i = 0; i < NumRecs; i++) begin
      rec_level[i] = '0; rec_alloc[i] = 0; rec_has_next[i] = 0; rec_has_prev[i] = 0;
      rec_next[i] = '0; rec_prev[i] = '0; rec_written[i] = 0;
    end
    for (int i = 0; i < NumLists; i++) begin
      head_valid[i] = 0;
      head_idx[i] = '0;
    end
    used_total = 0;
    sticky_error = 0;
    heap_base = '0;
    list_push(0, HeapOrder);
  endfunction

  // Works out the status word of one command and updates the allocator state.
  function automatic reply_t allocator_step(logic cmd, logic [39:0] req, logic [47:0] addr);
    longint unsigned size;
    logic [47:0] off;
    int lvl, i, idx, bidx;
    if (sticky_error) return make_reply(StBlocked, '0);
    if (cmd == CmdAlloc) begin
      size = 64'(req) + HeaderBytes;
      if (size < 8) size = 8;
      lvl = 0;
      while (lvl < 63 && (64'd1 << lvl) < size) lvl++;
      if (lvl > MaxOrder) begin
        sticky_error = 1'b1;
        return make_reply(StTooBig, '0);
      end
      i = lvl;
      while (i < NumLists && !head_valid[i]) i++;
      if (i >= NumLists) return make_reply(StNoSpace, '0);
      idx = head_idx[i];
      list_unlink(idx);
      while (i > lvl) begin
        i--;
        list_push(idx + (1 << (i - MinOrder)), i);
      end
      rec_level[idx] = lvl[5:0];
      rec_alloc[idx] = 1'b1;
      used_total += 1 << lvl;
      return make_reply(StOk, heap_base + 48'(idx << MinOrder) + HeaderBytes);
    end
    off = addr - HeaderBytes - heap_base;
    if (addr == 0 || off >= HeapBytes || off[2:0] != 0) return make_reply(StBadFree, '0);
    idx = int'(off >> MinOrder);
    if (!rec_alloc[idx] || rec_level[idx] > HeapOrder) return make_reply(StBadFree, '0);
    lvl = rec_level[idx];
    used_total -= 1 << lvl;
    list_push(idx, lvl);
    // Merge upward while the buddy is a free block of the same order.
    while (lvl < HeapOrder) begin
      bidx = ((idx << MinOrder) ^ (1 << lvl)) >> MinOrder;
      if (rec_alloc[bidx] || rec_level[bidx] != lvl) break;
      list_unlink(bidx);
      list_unlink(idx);
      if (bidx < idx) idx = bidx;
      lvl++;
      list_push(idx, lvl);
    end
    return make_reply(StOk, '0);
  endfunction

  // Sends one command word, predicts its reply and tracks live blocks.
  task automatic send_command(logic cmd, logic [39:0] req, logic [47:0] addr);
    int gap;
    reply_t r;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, addr, req, cmd};
    do @(posedge clk); while (!s_axis_tready);
    r = allocator_step(cmd, req, addr);
    pending_replies.push_back(r);
    if (cmd == CmdAlloc && r.status == StOk)
      live_offsets.push_back(int'(48'(r.granted - heap_base)));
  endtask

  task automatic alloc_bytes(logic [39:0] req);
    send_command(CmdAlloc, req, '0);
  endtask

  task automatic free_addr(logic [47:0] addr);
    send_command(CmdFree, '0, addr);
  endtask

  function automatic logic [47:0] live_addr(int k);
    return heap_base + 48'(live_offsets[k]);
  endfunction

  // Frees a random live block and drops it from the live list.
  task automatic free_random_live();
    int k;
    logic [47:0] a;
    k = $urandom_range(live_offsets.size() - 1);
    a = live_addr(k);
    live_offsets.delete(k);
    free_addr(a);
  endtask

  // An address that a free must reject without reading a never-written record.
  function automatic logic [47:0] bad_free_address();
    logic [47:0] a, off;
    int idx;
    case ($urandom_range(4))
      0: return '0;
      1: if (live_offsets.size() > 0)
        return live_addr($urandom_range(live_offsets.size() - 1)) + $urandom_range(7, 1);
      2: return heap_base + HeaderBytes + HeapBytes + 48'($urandom_range(4096) * 8);
      3: begin
        // Written granule that holds no allocated block (stale or free).
        for (int t = 0; t < 40; t++) begin
          idx = $urandom_range(NumRecs - 1);
          if (rec_written[idx] && !rec_alloc[idx])
            return heap_base + 48'(idx * 8) + HeaderBytes;
        end
      end
      default: begin
        a = 48'({$urandom, $urandom}) & AddrMask;
        off = a - HeaderBytes - heap_base;
        if (off >= HeapBytes) return a;
      end
    endcase
    return heap_base + HeaderBytes - 48'($urandom_range(HeaderBytes, 1));
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_heap_base(logic [47:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegHeapBase; pwdata <= {16'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    heap_base = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Size extremes, exact fits, no space, every kind of rejected free, merges.
  task automatic test_directed();
    logic [47:0] a;
    alloc_bytes(40'd65512);
    alloc_bytes(40'd0);
    free_addr(live_addr(0));
    live_offsets.delete();
    alloc_bytes(40'd65513);
    alloc_bytes(40'd4294967272);
    alloc_bytes(40'd0);
    alloc_bytes(40'd8);
    alloc_bytes(40'd9);
    alloc_bytes(40'd1000);
    free_addr('0);
    free_addr(live_addr(0) + 48'd4);
    free_addr(heap_base + HeaderBytes + HeapBytes);
    free_addr(heap_base + 48'd8);
    a = live_addr(1);
    free_addr(a);
    free_addr(a);
    live_offsets.delete(1);
    while (live_offsets.size() > 0) free_random_live();
    alloc_bytes(40'd32744);
    alloc_bytes(40'd32744);
    alloc_bytes(40'd1);
    while (live_offsets.size() > 0) free_random_live();
  endtask

  task automatic test_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        wait_drained();
      end else if (pick < 52 || (pick < 88 && live_offsets.size() == 0)) begin
        case ($urandom_range(19))
          0: alloc_bytes(40'($urandom_range(40000)));
          1: alloc_bytes(40'($urandom_range(32'hFFFF_FFE8, 65513)));
          2: alloc_bytes(40'(65512));
          3, 4, 5: alloc_bytes(40'($urandom_range(4000)));
          default: alloc_bytes(40'($urandom_range(200)));
        endcase
      end else if (pick < 88) begin
        free_random_live();
      end else begin
        free_addr(bad_free_address());
      end
    end
  endtask

  // Receiver holds off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    hold_go = 1'b1;
    repeat (12) alloc_bytes(40'($urandom_range(300)));
    while (live_offsets.size() > 0) free_random_live();
  endtask

  // A too-large request sets the sticky error; everything after is blocked.
  task automatic test_sticky_error();
    alloc_bytes(40'($urandom_range(100)));
    alloc_bytes(40'hFF_FFFF_FFFF);
    repeat (20) begin
      if ($urandom_range(1)) alloc_bytes(40'({$urandom, $urandom}));
      else free_addr(48'({$urandom, $urandom}));
    end
    if (live_offsets.size() > 0) free_addr(live_addr(0));
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted status word with the oldest prediction.
  always @(posedge clk) begin
    reply_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        e = pending_replies.pop_front();
        if (m_axis_tdata[2:0] !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, m_axis_tdata[2:0]);
          mismatches++;
        end
        if (m_axis_tdata[50:3] !== e.granted) begin
          $display("%0t: granted exp %h got %h", $time, e.granted, m_axis_tdata[50:3]);
          mismatches++;
        end
        if (m_axis_tdata[67:51] !== e.used) begin
          $display("%0t: used exp %0d got %0d", $time, e.used, m_axis_tdata[67:51]);
          mismatches++;
        end
        if (m_axis_tdata[84:68] !== e.free_b) begin
          $display("%0t: free exp %0d got %0d", $time, e.free_b, m_axis_tdata[84:68]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    hold_go = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 81;
    reset_allocator();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_heap_base(48'h0);
    test_directed();
    test_random(650);
    test_backpressure();

    send_idle_pct = 81;
    recv_idle_pct = 7;
    write_heap_base(48'hFFFF_FFFF_0000);
    test_directed();
    test_random(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_heap_base({16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 16'h0});
    test_random(650);
    test_sticky_error();

    wait_drained();
    repeat (320) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bba_pkg.sv
rtl/core/bba_rec_mem.sv
rtl/core/bba_seq.sv
rtl/core/buddy_block_allocator_top.sv
sim/tb_top.sv
